// File: rtl/assert_macros.svh
// assertion macros used by spin_table_release_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define STRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define STRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stru_pkg.sv
package stru_pkg;

  // fixed geometry of one table entry
  localparam int ENTRY_BYTES     = 32;
  localparam int NUM_ENTRIES_DEF = 32;
  localparam int ROW_W           = 5;
  localparam int ADDR_W          = 10;
  localparam int CNT_W           = 6;
  localparam int WINDOW_BITS     = 26;

  // bus access codes
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    SIZE_1B = 2'd0,
    SIZE_2B = 2'd1,
    SIZE_4B = 2'd2,
    SIZE_8B = 2'd3
  } size_t;

  // one entry, byte k of the entry at index k
  typedef logic [ENTRY_BYTES-1:0][7:0] row_t;

  // result of one beat
  typedef struct packed {
    logic [31:0]            read_data;
    logic                   bad_size;
    logic                   release_res;
    logic [ROW_W-1:0]       release_cpu;
    logic [WINDOW_BITS-1:0] start_offset;
    logic [63:0]            window_base;
    logic [63:0]            start_argument;
  } res_t;

  // write-back enables for the two rows of the access window
  typedef struct packed {
    logic lo_en;
    logic hi_en;
  } wr_ctl_t;

  // contents of an entry after reset: start 1, argument and id hold the row
  function automatic row_t row_init(logic [ROW_W-1:0] r);
    row_t v;
    v     = '0;
    v[7]  = 8'h01;
    v[15] = {3'b000, r};
    v[23] = {3'b000, r};
    return v;
  endfunction

endpackage

// File: rtl/spin_table_release_unit.sv
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+-------------------------
// request   | action address access_size write_data          | start high, busy low
// result    | read_data bad_size release_res release_cpu     | done, one cycle, no stall
//           | start_offset window_base start_argument        |
// config    | cfg_wdata (cpu_count)                          | cfg_we
//
// one beat is taken every cycle (busy stays low); the table rows are read at the
// accepting edge, merged and written back in the cycle after it, and the result
// register loads with the write-back, so done is high for the following cycle.
// the write-back of one beat is forwarded to the beat right behind it.
// synchronous reset, no clearing pass: rows not yet written read their reset
// contents through per-row written flags; the receiver cannot stall.
`include "assert_macros.svh"

module spin_table_release_unit #(
  parameter int NUM_ENTRIES = stru_pkg::NUM_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic [stru_pkg::ADDR_W-1:0]      address,
  input  logic [1:0]                       access_size,
  input  logic [31:0]                      write_data,
  input  logic                             cfg_we,
  input  logic [stru_pkg::CNT_W-1:0]       cfg_wdata,
  output logic                             done,
  output logic [31:0]                      read_data,
  output logic                             bad_size,
  output logic                             release_res,
  output logic [stru_pkg::ROW_W-1:0]       release_cpu,
  output logic [stru_pkg::WINDOW_BITS-1:0] start_offset,
  output logic [63:0]                      window_base,
  output logic [63:0]                      start_argument
);
  import stru_pkg::*;

  localparam int EVEN_ROWS = (NUM_ENTRIES + 1) / 2;
  localparam int ODD_ROWS  = NUM_ENTRIES / 2;
  localparam int EVEN_AW   = (EVEN_ROWS > 1) ? $clog2(EVEN_ROWS) : 1;
  localparam int ODD_AW    = (ODD_ROWS > 1) ? $clog2(ODD_ROWS) : 1;
  localparam logic [CNT_W-1:0] N_ROWS = CNT_W'(NUM_ENTRIES);

  logic [CNT_W-1:0]   cpu_count;
  logic               s1_valid;
  logic               s1_action;
  logic [ADDR_W-1:0]  s1_address;
  logic [1:0]         s1_size;
  logic [31:0]        s1_wdata;

  logic [ROW_W-1:0]   r0;
  logic [CNT_W-1:0]   even_row0;
  logic [CNT_W-1:0]   odd_row0;
  logic [EVEN_AW-1:0] even_rd_idx;
  logic [ODD_AW-1:0]  odd_rd_idx;

  logic [ROW_W-1:0]   r1;
  logic [CNT_W-1:0]   even_row1;
  logic [CNT_W-1:0]   odd_row1;
  logic [EVEN_AW-1:0] even_idx1;
  logic [ODD_AW-1:0]  odd_idx1;

  row_t               even_rd;
  row_t               odd_rd;
  row_t               even_cur;
  row_t               odd_cur;
  row_t               row_lo;
  row_t               row_hi;
  row_t               new_lo;
  row_t               new_hi;
  wr_ctl_t            wr;
  res_t               res;

  logic               even_we;
  logic               odd_we;
  row_t               even_wdata;
  row_t               odd_wdata;

  logic               byp_even_en;
  logic [EVEN_AW-1:0] byp_even_idx;
  row_t               byp_even_data;
  logic               byp_odd_en;
  logic [ODD_AW-1:0]  byp_odd_idx;
  row_t               byp_odd_data;

  assign busy = 1'b0;

  // processor count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_count <= CNT_W'(1);
    end else if (cfg_we) begin
      cpu_count <= cfg_wdata;
    end
  end

  // read addresses: row r and r+1 fall in opposite banks
  assign r0        = address[ADDR_W-1:ADDR_W-ROW_W];
  assign even_row0 = {1'b0, r0} + CNT_W'(r0[0]);
  assign odd_row0  = {1'b0, r0} + CNT_W'(!r0[0]);
  assign even_rd_idx = (even_row0 < N_ROWS) ? even_row0[EVEN_AW:1] : '0;
  assign odd_rd_idx  = (odd_row0 < N_ROWS) ? odd_row0[ODD_AW:1] : '0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_action  <= action;
      s1_address <= address;
      s1_size    <= access_size;
      s1_wdata   <= write_data;
    end
  end

  stru_bank #(
    .DEPTH  (EVEN_ROWS),
    .PARITY (0)
  ) u_even (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (even_rd_idx),
    .rd_data (even_rd),
    .wr_en   (even_we),
    .wr_idx  (even_idx1),
    .wr_data (even_wdata)
  );

  stru_bank #(
    .DEPTH  (ODD_ROWS),
    .PARITY (1)
  ) u_odd (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (odd_rd_idx),
    .rd_data (odd_rd),
    .wr_en   (odd_we),
    .wr_idx  (odd_idx1),
    .wr_data (odd_wdata)
  );

  // second stage row numbers
  assign r1        = s1_address[ADDR_W-1:ADDR_W-ROW_W];
  assign even_row1 = {1'b0, r1} + CNT_W'(r1[0]);
  assign odd_row1  = {1'b0, r1} + CNT_W'(!r1[0]);
  assign even_idx1 = (even_row1 < N_ROWS) ? even_row1[EVEN_AW:1] : '0;
  assign odd_idx1  = (odd_row1 < N_ROWS) ? odd_row1[ODD_AW:1] : '0;

  // forward the previous beat's write-back, it landed with this beat's read
  assign even_cur = (byp_even_en && (byp_even_idx == even_idx1)) ? byp_even_data : even_rd;
  assign odd_cur  = (byp_odd_en && (byp_odd_idx == odd_idx1)) ? byp_odd_data : odd_rd;

  assign row_lo = r1[0] ? odd_cur : even_cur;
  assign row_hi = r1[0] ? even_cur : odd_cur;

  stru_merge #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_merge (
    .action      (s1_action),
    .address     (s1_address),
    .access_size (s1_size),
    .write_data  (s1_wdata),
    .cpu_count   (cpu_count),
    .row_lo      (row_lo),
    .row_hi      (row_hi),
    .new_lo      (new_lo),
    .new_hi      (new_hi),
    .wr          (wr),
    .res         (res)
  );

  // steer write-back to the banks
  assign even_we    = s1_valid && (r1[0] ? wr.hi_en : wr.lo_en);
  assign odd_we     = s1_valid && (r1[0] ? wr.lo_en : wr.hi_en);
  assign even_wdata = r1[0] ? new_hi : new_lo;
  assign odd_wdata  = r1[0] ? new_lo : new_hi;

  // forwarding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_even_en <= 1'b0;
      byp_odd_en  <= 1'b0;
    end else begin
      byp_even_en <= even_we;
      byp_odd_en  <= odd_we;
    end
  end

  always_ff @(posedge clk) begin
    byp_even_idx  <= even_idx1;
    byp_even_data <= even_wdata;
    byp_odd_idx   <= odd_idx1;
    byp_odd_data  <= odd_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      read_data      <= res.read_data;
      bad_size       <= res.bad_size;
      release_res    <= res.release_res;
      release_cpu    <= res.release_cpu;
      start_offset   <= res.start_offset;
      window_base    <= res.window_base;
      start_argument <= res.start_argument;
    end
  end

  // checks
  `STRU_ASSERT_NEXT(a_done_follows, s1_valid, done, "result strobe missing after a beat")
  `STRU_ASSERT_NOW(a_bad_size_read, done && bad_size, (read_data == 32'h0) && !release_res,
                   "size error carries data or a release")
  `STRU_ASSERT_NOW(a_release_cpu, done && release_res,
                   (release_cpu != '0) && (read_data == 32'h0) && !bad_size,
                   "release reported for processor 0 or with read fields")
  `STRU_ASSERT_NOW(a_wb_has_beat, even_we || odd_we, s1_valid,
                   "table write-back without a beat in flight")

endmodule

// File: rtl/stru_bank.sv
module stru_bank #(
  parameter int DEPTH  = 16,
  parameter int PARITY = 0,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [AW-1:0]  rd_idx,
  output stru_pkg::row_t rd_data,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_idx,
  input  stru_pkg::row_t wr_data
);
  import stru_pkg::*;

  localparam logic PARITY_BIT = 1'(PARITY);

  row_t             mem [DEPTH];
  row_t             rd_q;
  logic [AW-1:0]    rd_idx_q;
  logic [DEPTH-1:0] vld;
  logic             rd_vld;

  // row storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q     <= mem[rd_idx];
    rd_idx_q <= rd_idx;
  end

  // written flags, a row never written reads as its reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      rd_vld <= vld[rd_idx];
    end
  end

  assign rd_data = rd_vld ? rd_q : row_init(ROW_W'({rd_idx_q, PARITY_BIT}));

endmodule

// File: rtl/stru_merge.sv
module stru_merge #(
  parameter int NUM_ENTRIES = 32
) (
  input  logic                          action,
  input  logic [stru_pkg::ADDR_W-1:0]   address,
  input  logic [1:0]                    access_size,
  input  logic [31:0]                   write_data,
  input  logic [stru_pkg::CNT_W-1:0]    cpu_count,
  input  stru_pkg::row_t                row_lo,
  input  stru_pkg::row_t                row_hi,
  output stru_pkg::row_t                new_lo,
  output stru_pkg::row_t                new_hi,
  output stru_pkg::wr_ctl_t             wr,
  output stru_pkg::res_t                res
);
  import stru_pkg::*;

  localparam logic [CNT_W-1:0] N_ROWS = CNT_W'(NUM_ENTRIES);

  logic [ROW_W-1:0]     r;
  logic [4:0]           off;
  logic                 lo_in;
  logic                 hi_in;
  logic                 wr_ok;
  logic                 store;
  size_t                sz;
  logic [2:0]           nbytes;
  logic [63:0][7:0]     win;
  logic [63:0][7:0]     win_w;
  logic [7:0]           rb [4];
  logic [7:0]           wb [4];
  logic [63:0]          start_addr;
  logic [63:0]          arg;
  row_t                 lo_w;

  assign r     = address[ADDR_W-1:ADDR_W-ROW_W];
  assign off   = address[4:0];
  assign sz    = size_t'(access_size);
  assign lo_in = {1'b0, r} < N_ROWS;
  assign hi_in = ({1'b0, r} + CNT_W'(1)) < N_ROWS;

  // two-row window, rows past the table read as zero
  assign win = {(hi_in ? row_hi : row_t'('0)), (lo_in ? row_lo : row_t'('0))};

  // byte lanes of the write data, most significant first
  always_comb begin
    wb[0] = 8'h00;
    wb[1] = 8'h00;
    wb[2] = 8'h00;
    wb[3] = 8'h00;
    unique case (sz)
      SIZE_1B: begin
        nbytes = 3'd1;
        wb[0]  = write_data[7:0];
      end
      SIZE_2B: begin
        nbytes = 3'd2;
        wb[0]  = write_data[15:8];
        wb[1]  = write_data[7:0];
      end
      SIZE_4B: begin
        nbytes = 3'd4;
        wb[0]  = write_data[31:24];
        wb[1]  = write_data[23:16];
        wb[2]  = write_data[15:8];
        wb[3]  = write_data[7:0];
      end
      SIZE_8B: begin
        nbytes = 3'd0;
      end
    endcase
  end

  // write acceptance: never processor 0, nor past the table or processor count
  assign wr_ok = (action == ACT_WRITE) && (r != '0) && lo_in && ({1'b0, r} < cpu_count);
  assign store = wr_ok && (sz != SIZE_8B);

  // read bytes and merge write bytes into the window
  always_comb begin
    win_w = win;
    for (int i = 0; i < 4; i++) begin
      rb[i] = win[6'({1'b0, off}) + 6'(i)];
      if (store && (3'(i) < nbytes)) begin
        win_w[6'({1'b0, off}) + 6'(i)] = wb[i];
      end
    end
  end

  // start address and argument of the entry after the store
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      start_addr[8*(7-k) +: 8] = win_w[k];
      arg[8*(7-k) +: 8]        = win_w[8+k];
    end
  end

  // release rewrites the id word with the processor number
  always_comb begin
    lo_w = row_t'(win_w[31:0]);
    if (wr_ok && !start_addr[0]) begin
      lo_w[20] = 8'h00;
      lo_w[21] = 8'h00;
      lo_w[22] = 8'h00;
      lo_w[23] = {3'b000, r};
    end
  end

  assign new_lo   = lo_w;
  assign new_hi   = row_t'(win_w[63:32]);
  assign wr.lo_en = wr_ok;
  assign wr.hi_en = store && hi_in;

  // result fields, zero where they do not apply
  always_comb begin
    res = '0;
    if (action == ACT_READ) begin
      unique case (sz)
        SIZE_1B: res.read_data = {24'h0, rb[0]};
        SIZE_2B: res.read_data = {16'h0, rb[0], rb[1]};
        SIZE_4B: res.read_data = {rb[0], rb[1], rb[2], rb[3]};
        SIZE_8B: res.bad_size  = 1'b1;
      endcase
    end else if (wr_ok && !start_addr[0]) begin
      res.release_res    = 1'b1;
      res.release_cpu    = r;
      res.start_offset   = start_addr[WINDOW_BITS-1:0];
      res.window_base    = {start_addr[63:WINDOW_BITS], {WINDOW_BITS{1'b0}}};
      res.start_argument = arg;
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import stru_pkg::*;

  localparam int TBL_BYTES   = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 6;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic              start       = 1'b0;
  logic              busy;
  logic              action      = ACT_READ;
  logic [ADDR_W-1:0] address     = '0;
  logic [1:0]        access_size = SIZE_1B;
  logic [31:0]       write_data  = '0;
  logic              cfg_we      = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata   = '0;
  logic              done;
  logic [31:0]       read_data;
  logic              bad_size;
  logic              release_res;
  logic [ROW_W-1:0]  release_cpu;
  logic [WINDOW_BITS-1:0] start_offset;
  logic [63:0]       window_base;
  logic [63:0]       start_argument;

  spin_table_release_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .address        (address),
    .access_size    (access_size),
    .write_data     (write_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .read_data      (read_data),
    .bad_size       (bad_size),
    .release_res    (release_res),
    .release_cpu    (release_cpu),
    .start_offset   (start_offset),
    .window_base    (window_base),
    .start_argument (start_argument)
  );

  // shadow copy of the table and the processor count
  logic [7:0]       shadow_tbl [TBL_BYTES];
  logic [CNT_W-1:0] shadow_cpus;
  res_t             pending_res [$];
  int               err_count = 0;
  int               cycle_count = 0;
  bit               no_gaps = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // table contents after reset
  function automatic void reset_shadow();
    for (int k = 0; k < TBL_BYTES; k++) shadow_tbl[k] = 8'h00;
    for (int e = 0; e < TBL_BYTES / ENTRY_BYTES; e++) begin
      shadow_tbl[e * ENTRY_BYTES + 7]  = 8'h01;
      shadow_tbl[e * ENTRY_BYTES + 15] = 8'(e);
      shadow_tbl[e * ENTRY_BYTES + 23] = 8'(e);
    end
    shadow_cpus = 6'd1;
  endfunction

  // big-endian load, bytes past the end read as zero
  function automatic logic [63:0] load_bytes(input int a, input int n);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < n; k++)
      v = {v[55:0], (a + k < TBL_BYTES) ? shadow_tbl[a + k] : 8'h00};
    return v;
  endfunction

  // big-endian store, bytes past the end are dropped
  function automatic void store_bytes(input int a, input int n, input logic [63:0] v);
    for (int k = 0; k < n; k++)
      if (a + k < TBL_BYTES) shadow_tbl[a + k] = v[8 * (n - 1 - k) +: 8];
  endfunction

  // expected result of one beat, updating the shadow table
  function automatic res_t predict_access(input logic act, input logic [ADDR_W-1:0] a,
                                          input size_t sz, input logic [31:0] wd);
    res_t r;
    int   idx;
    int   base;
    logic [63:0] st_addr;
    r = '0;
    if (act == ACT_READ) begin
      if (sz == SIZE_8B) r.bad_size = 1'b1;
      else r.read_data = 32'(load_bytes(int'(a), 1 << int'(sz)));
      return r;
    end
    idx = int'(a) / ENTRY_BYTES;
    if (idx == 0 || idx >= int'(shadow_cpus)) return r;
    if (sz != SIZE_8B) store_bytes(int'(a), 1 << int'(sz), {32'h0, wd});
    base    = idx * ENTRY_BYTES;
    st_addr = load_bytes(base, 8);
    if (!st_addr[0]) begin
      store_bytes(base + 20, 4, 64'(idx));
      r.release_res    = 1'b1;
      r.release_cpu    = ROW_W'(idx);
      r.start_offset   = st_addr[WINDOW_BITS-1:0];
      r.window_base    = {st_addr[63:WINDOW_BITS], {WINDOW_BITS{1'b0}}};
      r.start_argument = load_bytes(base + 8, 8);
    end
    return r;
  endfunction

  // monitor: check each result, then predict the beat taken at this edge
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      reset_shadow();
    end else begin
      if (done) begin
        if (pending_res.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(done), 64'(0));
        end else begin
          want = pending_res.pop_front();
          if (read_data !== want.read_data)
            report_mismatch("read_data", 64'(read_data), 64'(want.read_data));
          if (bad_size !== want.bad_size)
            report_mismatch("bad_size", 64'(bad_size), 64'(want.bad_size));
          if (release_res !== want.release_res)
            report_mismatch("release_res", 64'(release_res), 64'(want.release_res));
          if (release_cpu !== want.release_cpu)
            report_mismatch("release_cpu", 64'(release_cpu), 64'(want.release_cpu));
          if (start_offset !== want.start_offset)
            report_mismatch("start_offset", 64'(start_offset), 64'(want.start_offset));
          if (window_base !== want.window_base)
            report_mismatch("window_base", window_base, want.window_base);
          if (start_argument !== want.start_argument)
            report_mismatch("start_argument", start_argument, want.start_argument);
        end
      end
      if (cfg_we) shadow_cpus = cfg_wdata;
      if (start && !busy)
        pending_res.push_back(predict_access(action, address, size_t'(access_size),
                                             write_data));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // drive one beat and hold it until taken, then idle for a random gap
  task automatic send_beat(input logic act, input int a, input size_t sz,
                           input logic [31:0] wd);
    int gap;
    start       <= 1'b1;
    action      <= act;
    address     <= ADDR_W'(a);
    access_size <= sz;
    write_data  <= wd;
    do @(posedge clk); while (busy);
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_cpu_count(input logic [CNT_W-1:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // reset contents, every size and writes that the reset count drops
  task automatic test_reset_contents();
    send_beat(ACT_READ, 4, SIZE_4B, 32'h0);
    send_beat(ACT_READ, 15, SIZE_1B, 32'h0);
    send_beat(ACT_READ, 31 * ENTRY_BYTES + 20, SIZE_4B, 32'h0);
    send_beat(ACT_READ, 6, SIZE_2B, 32'h0);
    send_beat(ACT_READ, 0, SIZE_8B, 32'h0);
    send_beat(ACT_WRITE, ENTRY_BYTES + 4, SIZE_4B, 32'h0);
    send_beat(ACT_READ, ENTRY_BYTES + 4, SIZE_4B, 32'h0);
  endtask

  // release on an even start address, none on an odd one
  task automatic test_release();
    set_cpu_count(6'd32);
    send_beat(ACT_WRITE, 3 * ENTRY_BYTES + 8, SIZE_4B, 32'hFFFF_FFFF);
    send_beat(ACT_WRITE, 3 * ENTRY_BYTES + 4, SIZE_4B, 32'h1234_5679);
    send_beat(ACT_WRITE, 3 * ENTRY_BYTES, SIZE_4B, 32'hFFFF_FFFF);
    send_beat(ACT_WRITE, 3 * ENTRY_BYTES + 4, SIZE_4B, 32'hFFFF_FFFE);
    send_beat(ACT_READ, 3 * ENTRY_BYTES + 20, SIZE_4B, 32'h0);
    // eight-byte write stores nothing but still checks the start address
    send_beat(ACT_WRITE, 4 * ENTRY_BYTES, SIZE_8B, 32'h0);
    send_beat(ACT_WRITE, 4 * ENTRY_BYTES + 7, SIZE_1B, 32'h0000_0000);
    send_beat(ACT_WRITE, 4 * ENTRY_BYTES + 12, SIZE_8B, 32'hFFFF_FFFF);
  endtask

  // processor 0, entries above the count, boundary and end-of-table crossing
  task automatic test_bounds();
    send_beat(ACT_WRITE, 6, SIZE_2B, 32'h0000_0000);
    send_beat(ACT_WRITE, 6 * ENTRY_BYTES + 30, SIZE_4B, 32'hA5A5_0000);
    send_beat(ACT_READ, 6 * ENTRY_BYTES + 30, SIZE_4B, 32'h0);
    send_beat(ACT_WRITE, TBL_BYTES - 2, SIZE_4B, 32'h0102_0304);
    send_beat(ACT_READ, TBL_BYTES - 2, SIZE_4B, 32'h0);
    send_beat(ACT_READ, TBL_BYTES - 1, SIZE_2B, 32'h0);
    set_cpu_count(6'd5);
    send_beat(ACT_WRITE, 5 * ENTRY_BYTES + 4, SIZE_4B, 32'h0);
    send_beat(ACT_WRITE, 4 * ENTRY_BYTES + 4, SIZE_4B, 32'h0000_1000);
  endtask

  // mostly boot sequences with random content, the rest random beats
  task automatic test_random_traffic(input int n_items);
    int    sent;
    int    idx;
    int    base;
    size_t sz;
    logic [31:0] lo_word;
    sent = 0;
    while (sent < n_items) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 6) begin
        idx  = $urandom_range(0, 31);
        base = idx * ENTRY_BYTES;
        send_beat(ACT_WRITE, base + 8, SIZE_4B, $urandom());
        send_beat(ACT_WRITE, base + 12, SIZE_4B, $urandom());
        send_beat(ACT_WRITE, base, SIZE_4B, $urandom());
        lo_word = $urandom();
        if ($urandom_range(0, 3) != 0) lo_word[0] = 1'b0;
        sz = ($urandom_range(0, 4) == 0) ? SIZE_8B : SIZE_4B;
        send_beat(ACT_WRITE, base + 4, sz, lo_word);
        send_beat(ACT_READ, base + 20, SIZE_4B, 32'h0);
        sent += 5;
      end else begin
        repeat (4) begin
          sz = size_t'($urandom_range(0, 3));
          send_beat(1'($urandom_range(0, 1)), $urandom_range(0, TBL_BYTES - 1), sz,
                    $urandom());
        end
        sent += 4;
      end
    end
    no_gaps = 1'b0;
  endtask

  // sequence of tests and final verdict
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_contents();
    test_release();
    test_bounds();
    set_cpu_count(6'd32);
    test_random_traffic(260);
    set_cpu_count(6'd0);
    test_random_traffic(250);
    set_cpu_count(6'd63);
    test_random_traffic(260);
    set_cpu_count(6'd1);
    test_random_traffic(250);
    set_cpu_count(6'd2);
    test_random_traffic(250);
    set_cpu_count(6'd31);
    test_random_traffic(260);
    set_cpu_count(6'($urandom_range(1, 32)));
    test_random_traffic(260);
    drain_results();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: spin_table_release_unit.f
+incdir+rtl
rtl/stru_pkg.sv
rtl/stru_bank.sv
rtl/stru_merge.sv
rtl/spin_table_release_unit.sv
tb/sv/tb.sv
